// ----- hw/rtl/etalm_pkg.sv -----
// Shared types and constants for the echo time to level alarm block.
package etalm_pkg;

  // Input word kinds carried on tuser
  localparam logic [1:0] ACT_ECHO      = 2'd0;
  localparam logic [1:0] ACT_LINK_UP   = 2'd1;
  localparam logic [1:0] ACT_LINK_DOWN = 2'd2;

  // Configuration register indexes
  localparam logic [7:0] REG_TANK_HEIGHT    = 8'd0;
  localparam logic [7:0] REG_RESERVE_MARGIN = 8'd1;

  localparam logic [15:0] TANK_HEIGHT_RST    = 16'd200;
  localparam logic [15:0] RESERVE_MARGIN_RST = 16'd10;

  // Accepted echo window in microseconds
  localparam logic [31:0] ECHO_MIN_US = 32'd5;
  localparam logic [31:0] ECHO_MAX_US = 32'd60000;

  // cm = half_us * 340 * 100 / 1e6, reduced to half_us * 17 / 500
  localparam int unsigned SOUND_SPEED_MPS = 340;
  localparam int unsigned CM_PER_M        = 100;
  localparam int unsigned US_PER_S        = 1000000;
  localparam int unsigned DIST_GCD        = 2000;
  localparam int unsigned DIST_NUM        = SOUND_SPEED_MPS * CM_PER_M / DIST_GCD;
  localparam int unsigned DIST_DEN        = US_PER_S / DIST_GCD;
  localparam int unsigned PCT_SCALE       = 100;

  // Divider dividend width: covers 65535 * 100
  localparam int unsigned DIV_W   = 23;
  localparam int unsigned DIVR_W  = 16;
  localparam int unsigned DCNT_W  = 5;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_LVL,
    ST_PCT,
    ST_OUT
  } state_e;

endpackage

// ----- hw/rtl/etalm_div.sv -----
// Restoring divider, one quotient bit per cycle.
module etalm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  etalm_pkg::div_req_t req_i,
  output etalm_pkg::div_rsp_t rsp_o
);

  logic [etalm_pkg::DIV_W-1:0]  quot_q, quot_d;
  logic [etalm_pkg::DIVR_W-1:0] rem_q, rem_d;
  logic [etalm_pkg::DIVR_W-1:0] divisor_q, divisor_d;
  logic [etalm_pkg::DCNT_W-1:0] cnt_q, cnt_d;
  logic                         done_q, done_d;
  logic [etalm_pkg::DIVR_W:0]   shifted;
  logic [etalm_pkg::DIVR_W:0]   diff;
  logic                         ge;

  always_comb begin
    shifted = {rem_q, quot_q[etalm_pkg::DIV_W-1]};
    diff    = shifted - {1'b0, divisor_q};
    ge      = shifted >= {1'b0, divisor_q};
    quot_d    = quot_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    if (req_i.start) begin
      quot_d    = req_i.dividend;
      rem_d     = '0;
      divisor_d = req_i.divisor;
      cnt_d     = etalm_pkg::DCNT_W'(etalm_pkg::DIV_W);
    end else if (cnt_q != '0) begin
      quot_d = {quot_q[etalm_pkg::DIV_W-2:0], ge};
      rem_d  = ge ? diff[etalm_pkg::DIVR_W-1:0] : shifted[etalm_pkg::DIVR_W-1:0];
      cnt_d  = cnt_q - etalm_pkg::DCNT_W'(1);
      done_d = (cnt_q == etalm_pkg::DCNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q    <= quot_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ----- hw/rtl/echo_time_level_alarm.sv -----
// Top level: echo time to tank level, fill percent and high water alarm.
//
// For each echo word one shared restoring divider runs twice, first for the
// distance (half echo time * 17 / 500) and then for the fill percent (level *
// 100 / height); the percent division is skipped when the tank height is zero.
// Link up/down words and dropped echoes (below 5 us or above 60000 us, or an
// unused kind) are taken while idle and give no result. s_axis_tready is low
// while an echo word is being worked on. The result is held in an output
// register; a new word is taken while it waits.
// Configuration writes are taken at any time and should be made while idle.
module echo_time_level_alarm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] echo_us
  input  logic [1:0]  s_axis_tuser,  // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [15:0] level_cm, [22:16] fill_percent,
                                     // [23] near_full, [24] alarm_event, rest 0
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  etalm_pkg::state_e   state_q, state_d;
  etalm_pkg::div_req_t div_req;
  etalm_pkg::div_rsp_t div_rsp;

  logic [15:0] height_q, margin_q;
  logic        link_q, latched_q;
  logic [15:0] level_q;
  logic [6:0]  pct_q;
  logic        near_q;
  logic        m_valid_q;
  logic [31:0] m_data_q;

  logic        in_acc;
  logic        echo_ok;
  logic        out_free;
  logic        start_dist, start_pct, load_out;
  logic [14:0] half_us;
  logic [9:0]  dist_cm;
  logic        event_now;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign echo_ok  = (s_axis_tuser == etalm_pkg::ACT_ECHO) &&
                    (s_axis_tdata >= etalm_pkg::ECHO_MIN_US) &&
                    (s_axis_tdata <= etalm_pkg::ECHO_MAX_US);
  assign out_free = !m_valid_q || m_axis_tready;
  assign half_us  = s_axis_tdata[15:1];
  assign dist_cm  = div_rsp.quot[9:0];
  assign event_now = near_q && link_q && !latched_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      etalm_pkg::ST_IDLE: if (in_acc && echo_ok) state_d = etalm_pkg::ST_DIST;
      etalm_pkg::ST_DIST: begin
        if (div_rsp.done) begin
          state_d = (height_q == '0) ? etalm_pkg::ST_OUT : etalm_pkg::ST_LVL;
        end
      end
      etalm_pkg::ST_LVL:  state_d = etalm_pkg::ST_PCT;
      etalm_pkg::ST_PCT:  if (div_rsp.done) state_d = etalm_pkg::ST_OUT;
      etalm_pkg::ST_OUT:  if (out_free) state_d = etalm_pkg::ST_IDLE;
      default:            state_d = etalm_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    start_dist    = 1'b0;
    start_pct     = 1'b0;
    load_out      = 1'b0;
    unique case (state_q)
      etalm_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        start_dist    = s_axis_tvalid && echo_ok;
      end
      etalm_pkg::ST_DIST: ;
      etalm_pkg::ST_LVL:  start_pct = 1'b1;
      etalm_pkg::ST_PCT:  ;
      etalm_pkg::ST_OUT:  load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    div_req.start    = start_dist || start_pct;
    div_req.dividend = start_pct
                     ? etalm_pkg::DIV_W'(etalm_pkg::DIV_W'(level_q) *
                                         etalm_pkg::DIV_W'(etalm_pkg::PCT_SCALE))
                     : etalm_pkg::DIV_W'(etalm_pkg::DIV_W'(half_us) *
                                         etalm_pkg::DIV_W'(etalm_pkg::DIST_NUM));
    div_req.divisor  = start_pct ? height_q
                                 : etalm_pkg::DIVR_W'(etalm_pkg::DIST_DEN);
  end

  etalm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= etalm_pkg::ST_IDLE;
      height_q  <= etalm_pkg::TANK_HEIGHT_RST;
      margin_q  <= etalm_pkg::RESERVE_MARGIN_RST;
      link_q    <= 1'b0;
      latched_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == etalm_pkg::REG_TANK_HEIGHT) begin
          height_q <= cfg_data_i;
        end else if (cfg_index_i == etalm_pkg::REG_RESERVE_MARGIN) begin
          margin_q <= cfg_data_i;
        end
      end
      if (in_acc && s_axis_tuser == etalm_pkg::ACT_LINK_UP) begin
        link_q <= 1'b1;
      end else if (in_acc && s_axis_tuser == etalm_pkg::ACT_LINK_DOWN) begin
        link_q <= 1'b0;
      end
      if (load_out) begin
        if (!near_q) begin
          latched_q <= 1'b0;
        end else if (event_now) begin
          latched_q <= 1'b1;
        end
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == etalm_pkg::ST_DIST && div_rsp.done) begin
      level_q <= ({6'b0, dist_cm} >= height_q) ? 16'd0 : height_q - {6'b0, dist_cm};
      near_q  <= {6'b0, dist_cm} < margin_q;
      pct_q   <= '0;
    end
    if (state_q == etalm_pkg::ST_PCT && div_rsp.done) begin
      pct_q <= div_rsp.quot[6:0];
    end
    if (load_out) begin
      m_data_q <= {7'b0, event_now, near_q, pct_q, level_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cfg_ready_o   = 1'b1;

endmodule

// ----- verif/echo_time_level_alarm_test.sv -----
// Testbench for echo_time_level_alarm: directed table, then random phases checked by a predictor.
module echo_time_level_alarm_test;

  // Kind value the block must ignore
  localparam logic [1:0]  ACT_SPARE      = 2'd3;
  // Sound speed in cm/s, applied to the one-way time in us
  localparam int unsigned SOUND_CM_PER_S = 34000;
  localparam int unsigned US_PER_SEC     = 1000000;
  localparam int unsigned PCT_FULL       = 100;
  localparam int unsigned MAX_GAP        = 18;
  localparam int unsigned DRAIN_CYCLES   = 80;
  localparam int unsigned SINK_HOLD      = 400;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned PHASE_WORDS    = 110;

  typedef struct packed {
    logic [15:0] level;
    logic [6:0]  pct;
    logic        near;
    logic        alarm;
  } level_word_t;

  typedef enum logic {
    ROW_WORD,
    ROW_REG
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  act;
    logic [31:0] us;
    logic [7:0]  idx;
    logic [15:0] val;
    bit          typed;
    level_word_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  // Predictor copy of the registers and state
  logic [15:0] pr_height;
  logic [15:0] pr_margin;
  bit          pr_link;
  bit          pr_latched;

  level_word_t pending_levels[$];
  int unsigned mismatch_cnt = 0;
  bit          src_quiet = 1'b0;
  bit          sink_quiet = 1'b0;
  bit          sink_hold_req = 1'b0;

  echo_time_level_alarm i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    mismatch_cnt++;
  endtask

  // Level, percent and alarm for one word; updates link and latch state
  task automatic predict_level(input logic [1:0] act, input logic [31:0] us,
                               output bit hit, output level_word_t res);
    logic [63:0] prod;
    logic [31:0] dist_cm;
    logic [31:0] level;
    logic [31:0] pct;
    bit          near;
    hit = 1'b0;
    res = '0;
    case (act)
      etalm_pkg::ACT_LINK_UP:   pr_link = 1'b1;
      etalm_pkg::ACT_LINK_DOWN: pr_link = 1'b0;
      etalm_pkg::ACT_ECHO: begin
        if (us >= etalm_pkg::ECHO_MIN_US && us <= etalm_pkg::ECHO_MAX_US) begin
          prod    = 64'(us >> 1) * SOUND_CM_PER_S;
          dist_cm = 32'(prod / US_PER_SEC);
          level   = (dist_cm >= pr_height) ? 32'd0 : pr_height - dist_cm;
          pct     = (pr_height == 16'd0) ? 32'd0 : (level * PCT_FULL) / pr_height;
          near    = dist_cm < pr_margin;
          if (near) begin
            if (pr_link && !pr_latched) begin
              pr_latched = 1'b1;
              res.alarm  = 1'b1;
            end
          end else begin
            pr_latched = 1'b0;
          end
          res.level = level[15:0];
          res.pct   = pct[6:0];
          res.near  = near;
          hit       = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_word(input logic [1:0] act, input logic [31:0] us, input bit typed,
                           input level_word_t want);
    int unsigned gap;
    bit          hit;
    level_word_t res;
    gap = src_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= us;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_level(act, us, hit, res);
    if (hit) pending_levels.push_back(typed ? want : res);
  endtask

  // Let every expected word arrive, then cover a dropped word still in flight
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_levels.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == etalm_pkg::REG_TANK_HEIGHT) pr_height = val;
    else if (idx == etalm_pkg::REG_RESERVE_MARGIN) pr_margin = val;
    @(posedge clk_i);
  endtask

  function automatic stim_row_t word_row(input logic [1:0] act, input logic [31:0] us);
    stim_row_t r;
    r.kind  = ROW_WORD;
    r.act   = act;
    r.us    = us;
    r.idx   = '0;
    r.val   = '0;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic [31:0] us, input logic [15:0] lvl,
                                          input logic [6:0] pct, input bit nf, input bit ev);
    stim_row_t r;
    r = word_row(etalm_pkg::ACT_ECHO, us);
    r.typed      = 1'b1;
    r.want.level = lvl;
    r.want.pct   = pct;
    r.want.near  = nf;
    r.want.alarm = ev;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [7:0] idx, input logic [15:0] val);
    stim_row_t r;
    r = word_row(etalm_pkg::ACT_ECHO, '0);
    r.kind = ROW_REG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  function automatic logic [15:0] pick_span();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 20));
      default: return 16'($urandom_range(0, 1100));
    endcase
  endfunction

  always @(posedge clk_i) begin : level_check
    level_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_levels.size() == 0) begin
        flag_mismatch("word with none expected", m_axis_tdata, 32'd0);
      end else begin
        want = pending_levels.pop_front();
        if (m_axis_tdata[15:0] != want.level)
          flag_mismatch("level_cm", 32'(m_axis_tdata[15:0]), 32'(want.level));
        if (m_axis_tdata[22:16] != want.pct)
          flag_mismatch("fill_percent", 32'(m_axis_tdata[22:16]), 32'(want.pct));
        if (m_axis_tdata[23] != want.near)
          flag_mismatch("near_full", 32'(m_axis_tdata[23]), 32'(want.near));
        if (m_axis_tdata[24] != want.alarm)
          flag_mismatch("alarm_event", 32'(m_axis_tdata[24]), 32'(want.alarm));
        if (m_axis_tdata[31:25] != 7'd0)
          flag_mismatch("padding", 32'(m_axis_tdata[31:25]), 32'd0);
      end
    end
  end

  // Result sink: random back-pressure, one long hold on request
  initial begin : level_sink
    int unsigned gap;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (sink_hold_req) begin
        gap           = SINK_HOLD;
        sink_hold_req = 1'b0;
      end else begin
        gap = sink_quiet ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : watchdog
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   dir_tab[$];
    level_word_t nil;
    logic [1:0]  act;
    logic [31:0] us;
    int unsigned sel;
    int unsigned tgt;
    nil = '0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= etalm_pkg::ACT_ECHO;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= etalm_pkg::REG_TANK_HEIGHT;
    cfg_data_i    <= '0;
    pr_height  = etalm_pkg::TANK_HEIGHT_RST;
    pr_margin  = etalm_pkg::RESERVE_MARGIN_RST;
    pr_link    = 1'b0;
    pr_latched = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset config: height 200, margin 10, link down
    dir_tab.push_back(word_row(etalm_pkg::ACT_ECHO, 32'd0));
    dir_tab.push_back(word_row(etalm_pkg::ACT_ECHO, 32'd4));
    dir_tab.push_back(known_row(32'd5, 16'd200, 7'd100, 1'b1, 1'b0));
    dir_tab.push_back(known_row(32'd60000, 16'd0, 7'd0, 1'b0, 1'b0));
    dir_tab.push_back(word_row(etalm_pkg::ACT_ECHO, 32'd60001));
    dir_tab.push_back(word_row(etalm_pkg::ACT_ECHO, 32'hFFFF_FFFF));
    dir_tab.push_back(word_row(ACT_SPARE, 32'd100));
    dir_tab.push_back(word_row(etalm_pkg::ACT_LINK_UP, 32'hFFFF_FFFF));
    dir_tab.push_back(known_row(32'd5, 16'd200, 7'd100, 1'b1, 1'b1));
    dir_tab.push_back(known_row(32'd6, 16'd200, 7'd100, 1'b1, 1'b0));
    dir_tab.push_back(word_row(etalm_pkg::ACT_LINK_DOWN, 32'd0));
    dir_tab.push_back(known_row(32'd600, 16'd190, 7'd95, 1'b0, 1'b0));
    // near full while down: latch stays clear
    dir_tab.push_back(known_row(32'd500, 16'd192, 7'd96, 1'b1, 1'b0));
    dir_tab.push_back(word_row(etalm_pkg::ACT_LINK_UP, 32'd0));
    dir_tab.push_back(known_row(32'd500, 16'd192, 7'd96, 1'b1, 1'b1));
    dir_tab.push_back(word_row(etalm_pkg::ACT_ECHO, 32'd12345));
    // zero height and zero margin
    dir_tab.push_back(reg_row(etalm_pkg::REG_TANK_HEIGHT, 16'd0));
    dir_tab.push_back(reg_row(etalm_pkg::REG_RESERVE_MARGIN, 16'd0));
    dir_tab.push_back(known_row(32'd5, 16'd0, 7'd0, 1'b0, 1'b0));
    dir_tab.push_back(reg_row(etalm_pkg::REG_TANK_HEIGHT, 16'hFFFF));
    dir_tab.push_back(reg_row(etalm_pkg::REG_RESERVE_MARGIN, 16'hFFFF));
    dir_tab.push_back(known_row(32'd60000, 16'd64515, 7'd98, 1'b1, 1'b1));
    dir_tab.push_back(known_row(32'd5, 16'd65535, 7'd100, 1'b1, 1'b0));
    // writes to unmapped indexes must not land
    dir_tab.push_back(reg_row(8'hFF, 16'h0000));
    dir_tab.push_back(reg_row(8'd2, 16'hFFFF));
    dir_tab.push_back(word_row(etalm_pkg::ACT_ECHO, 32'd30000));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        settle();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_word(dir_tab[i].act, dir_tab[i].us, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      write_reg(etalm_pkg::REG_TANK_HEIGHT, pick_span());
      write_reg(etalm_pkg::REG_RESERVE_MARGIN, pick_span());
      src_quiet  = (phase == 2) || (phase == 5);
      sink_quiet = (phase == 2) || (phase == 6);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (phase == 1 && k == 30) sink_hold_req = 1'b1;
        if (phase == 3 && k == 50) begin
          s_axis_tvalid <= 1'b0;
          do @(posedge clk_i); while (pending_levels.size() != 0);
        end
        sel = $urandom_range(0, 99);
        us  = $urandom;
        if (sel < 6) begin
          act = etalm_pkg::ACT_LINK_UP;
        end else if (sel < 10) begin
          act = etalm_pkg::ACT_LINK_DOWN;
        end else if (sel < 13) begin
          act = ACT_SPARE;
        end else begin
          act = etalm_pkg::ACT_ECHO;
          if (sel < 20) begin
            if ($urandom_range(0, 1))
              us = $urandom_range(0, etalm_pkg::ECHO_MIN_US - 1);
            else
              us = $urandom_range(etalm_pkg::ECHO_MAX_US + 1, 32'hFFFF_FFFF);
          end else if (sel < 30) begin
            if ($urandom_range(0, 1))
              us = $urandom_range(etalm_pkg::ECHO_MIN_US, etalm_pkg::ECHO_MIN_US + 40);
            else
              us = $urandom_range(etalm_pkg::ECHO_MAX_US - 40, etalm_pkg::ECHO_MAX_US);
          end else if (sel < 60) begin
            // aim the distance at the reserve margin to toggle near_full
            tgt = pr_margin + $urandom_range(0, 6);
            tgt = (tgt > 3) ? tgt - 3 : 0;
            us  = tgt * 1000 / 17 + $urandom_range(0, 100);
            if (us < etalm_pkg::ECHO_MIN_US) us = etalm_pkg::ECHO_MIN_US;
            if (us > etalm_pkg::ECHO_MAX_US) us = etalm_pkg::ECHO_MAX_US;
          end else begin
            us = $urandom_range(etalm_pkg::ECHO_MIN_US, etalm_pkg::ECHO_MAX_US);
          end
        end
        send_word(act, us, 1'b0, nil);
      end
    end
    settle();

    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
